// ===== rtl/alrh_pkg.sv =====
// shared types and constants for the audio level ripple history unit
// no dependencies; imported by every module of the block except alrh_sqrt
`default_nettype none

package alrh_pkg;

  // fixed field widths
  localparam int LG_W     = 4;
  localparam int ALPHA_W  = 17;
  localparam int GAIN_W   = 24;
  localparam int BYTE_W   = 8;
  localparam int CFG_W    = 24;
  localparam int OFFSET_W = 5;
  localparam int CNT_W    = 12;
  localparam int SMOOTH_W = 41;
  localparam int STEP_W   = 3;

  // shared multiplier and accumulator
  localparam int MUL_W     = 32;
  localparam int ACC_W     = 64;
  localparam int CHUNK_W   = 24;
  localparam int LVL_EXT_W = 48;

  // limits
  localparam logic [CNT_W-1:0]   CNT_MAX   = 12'd4095;
  localparam logic [LG_W-1:0]    LG_MIN    = 4'd2;
  localparam logic [LG_W-1:0]    LG_MAX    = 4'd12;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [BYTE_W-1:0]  BYTE_MAX  = 8'd255;

  // register reset values
  localparam logic [LG_W-1:0]    RST_FRAME_LOG2 = 4'd10;
  localparam logic [ALPHA_W-1:0] RST_ALPHA      = 17'd19661;
  localparam logic [GAIN_W-1:0]  RST_GAIN       = 24'd65536;
  localparam logic [BYTE_W-1:0]  RST_GATE       = 8'd10;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_LOG2 = 2'd0,
    CFG_ALPHA      = 2'd1,
    CFG_GAIN       = 2'd2,
    CFG_GATE       = 2'd3
  } cfg_idx_t;

  // alignment of a product before it enters the accumulator
  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_UP8  = 2'd1,
    SH_UP24 = 2'd2,
    SH_DN16 = 2'd3
  } shsel_t;

  // accumulator control from the sequencer
  typedef struct packed {
    logic   load;
    logic   add;
    shsel_t sh;
  } mac_ctrl_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_SQ_SUM,
    ST_ROOT_GO,
    ST_ROOT,
    ST_LEVEL,
    ST_SMOOTH,
    ST_SAVE,
    ST_BRIGHT,
    ST_PUSH,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/audio_level_ripple_history_unit.sv =====
// audio level meter with smoothing, brightness and ripple history: top level
// depends on alrh_pkg, alrh_mac, alrh_sqrt, alrh_hist
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | in_bin_real, in_bin_imag, in_last_bin
//   out     | output    | out_valid/out_ready | out_ring_offset, out_level_byte, out_last_entry
//   cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// a bin outside the summed range skips the squaring; a summed bin waits on
// the square root unit that resolves one root bit per cycle
// a last bin adds level, smoothing and brightness steps on the shared multiplier, then HISTORY_DEPTH out requests
// in_ready is high only while the sequencer is idle; out stalls simply hold the run
// synchronous active-low reset restores the register defaults and clears all history
`default_nettype none

module audio_level_ripple_history_unit #(
  parameter int HISTORY_DEPTH = 32,
  parameter int BIN_WIDTH     = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input requests
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [BIN_WIDTH-1:0]   in_bin_real,
  input  wire logic signed [BIN_WIDTH-1:0]   in_bin_imag,
  input  wire logic                          in_last_bin,
  // result requests
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [alrh_pkg::OFFSET_W-1:0]      out_ring_offset,
  output logic [alrh_pkg::BYTE_W-1:0]        out_level_byte,
  output logic                               out_last_entry,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire alrh_pkg::cfg_idx_t            cfg_index,
  input  wire logic [alrh_pkg::CFG_W-1:0]    cfg_wdata
);
  import alrh_pkg::*;

  localparam int SUM_W = BIN_WIDTH + 12;
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // configuration registers
  logic [LG_W-1:0]    frame_log2_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [BYTE_W-1:0]  gate_r;

  // sequencer and datapath registers
  state_t                 state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [BIN_WIDTH-1:0]   re_mag_r, re_mag_nxt;
  logic [BIN_WIDTH-1:0]   im_mag_r, im_mag_nxt;
  logic                   last_r, last_nxt;
  logic [CNT_W-1:0]       bin_cnt_r, bin_cnt_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SUM_W-1:0]       level_r, level_nxt;
  logic [SMOOTH_W-1:0]    smooth_r, smooth_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // combinational
  logic [LG_W-1:0]        lg_eff;
  logic [LG_W-1:0]        shamt;
  logic [ALPHA_W-1:0]     alpha_eff;
  logic [ALPHA_W-1:0]     beta;
  logic [LVL_EXT_W-1:0]   level_ext;
  logic [BIN_WIDTH-1:0]   real_mag;
  logic [BIN_WIDTH-1:0]   imag_mag;
  logic                   in_range;
  logic                   in_accept;
  logic [BYTE_W-1:0]      bright_raw;
  logic [BYTE_W-1:0]      bright;
  logic [IDX_W+OFFSET_W-1:0] idx_ext;

  // shared unit connections
  logic [MUL_W-1:0]       op_a, op_b;
  mac_ctrl_t              mac_ctrl;
  logic [ACC_W-1:0]       mac_acc;
  logic                   sq_start;
  logic [BIN_WIDTH-1:0]   sq_root;
  logic                   sq_done;
  logic                   hist_push;
  logic                   hist_rotate;
  logic [BYTE_W-1:0]      hist_head;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_log2_r <= RST_FRAME_LOG2;
      alpha_r      <= RST_ALPHA;
      gain_r       <= RST_GAIN;
      gate_r       <= RST_GATE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_LOG2: frame_log2_r <= cfg_wdata[LG_W-1:0];
        CFG_ALPHA:      alpha_r      <= cfg_wdata[ALPHA_W-1:0];
        CFG_GAIN:       gain_r       <= cfg_wdata[GAIN_W-1:0];
        CFG_GATE:       gate_r       <= cfg_wdata[BYTE_W-1:0];
        default:        ;
      endcase
    end
  end

  // clamped settings
  assign lg_eff    = (frame_log2_r < LG_MIN) ? LG_MIN :
                     (frame_log2_r > LG_MAX) ? LG_MAX : frame_log2_r;
  assign shamt     = lg_eff - 1'b1;
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign beta      = ALPHA_ONE - alpha_eff;
  assign level_ext = LVL_EXT_W'(level_r);

  // bin magnitudes and summed range
  assign real_mag  = in_bin_real[BIN_WIDTH-1] ? ($unsigned(~in_bin_real) + 1'b1)
                                              : $unsigned(in_bin_real);
  assign imag_mag  = in_bin_imag[BIN_WIDTH-1] ? ($unsigned(~in_bin_imag) + 1'b1)
                                              : $unsigned(in_bin_imag);
  assign in_range  = (bin_cnt_r != '0) && ((bin_cnt_r >> shamt) == '0);
  assign in_accept = in_valid && in_ready;

  // brightness: clamp then noise gate
  assign bright_raw = (|mac_acc[ACC_W-1:24]) ? BYTE_MAX : mac_acc[23:16];
  assign bright     = (bright_raw < gate_r) ? '0 : bright_raw;

  // next state and unit control
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    re_mag_nxt    = re_mag_r;
    im_mag_nxt    = im_mag_r;
    last_nxt      = last_r;
    bin_cnt_nxt   = bin_cnt_r;
    sum_nxt       = sum_r;
    level_nxt     = level_r;
    smooth_nxt    = smooth_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    op_a          = '0;
    op_b          = '0;
    mac_ctrl      = '{load: 1'b0, add: 1'b0, sh: SH_NONE};
    sq_start      = 1'b0;
    hist_push     = 1'b0;
    hist_rotate   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          re_mag_nxt  = real_mag;
          im_mag_nxt  = imag_mag;
          last_nxt    = in_last_bin;
          bin_cnt_nxt = (bin_cnt_r == CNT_MAX) ? bin_cnt_r : (bin_cnt_r + 1'b1);
          if (in_last_bin) begin
            bin_cnt_nxt = '0;
          end
          if (in_range) begin
            state_nxt = ST_SQ_RE;
          end else if (in_last_bin) begin
            state_nxt = ST_LEVEL;
          end
        end
      end
      // re^2 + im^2 on the shared multiplier
      ST_SQ_RE: begin
        op_a      = MUL_W'(re_mag_r);
        op_b      = MUL_W'(re_mag_r);
        state_nxt = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        op_a          = MUL_W'(im_mag_r);
        op_b          = MUL_W'(im_mag_r);
        mac_ctrl.load = 1'b1;
        state_nxt     = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        mac_ctrl.add = 1'b1;
        state_nxt    = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        sq_start  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) begin
          sum_nxt   = sum_r + SUM_W'(sq_root);
          state_nxt = last_r ? ST_LEVEL : ST_IDLE;
        end
      end
      // frame average
      ST_LEVEL: begin
        level_nxt = sum_r >> shamt;
        sum_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_SMOOTH;
      end
      // alpha*level + ((1-alpha)*smoothed >> 16), products in 24-bit chunks
      ST_SMOOTH: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          3'd0: begin
            op_a = MUL_W'(alpha_eff);
            op_b = MUL_W'(level_ext[CHUNK_W-1:0]);
          end
          3'd1: begin
            op_a          = MUL_W'(alpha_eff);
            op_b          = MUL_W'(level_ext[LVL_EXT_W-1:CHUNK_W]);
            mac_ctrl.load = 1'b1;
          end
          3'd2: begin
            op_a         = MUL_W'(beta);
            op_b         = MUL_W'(smooth_r[CHUNK_W-1:0]);
            mac_ctrl.add = 1'b1;
            mac_ctrl.sh  = SH_UP24;
          end
          3'd3: begin
            op_a         = MUL_W'(beta);
            op_b         = MUL_W'(smooth_r[SMOOTH_W-1:CHUNK_W]);
            mac_ctrl.add = 1'b1;
            mac_ctrl.sh  = SH_DN16;
          end
          default: begin
            mac_ctrl.add = 1'b1;
            mac_ctrl.sh  = SH_UP8;
            state_nxt    = ST_SAVE;
          end
        endcase
      end
      ST_SAVE: begin
        smooth_nxt = mac_acc[SMOOTH_W-1:0];
        step_nxt   = '0;
        state_nxt  = ST_BRIGHT;
      end
      // (smoothed >> 16) * gain + ((smoothed & 0xffff) * gain >> 16)
      ST_BRIGHT: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          3'd0: begin
            op_a = MUL_W'(smooth_r[SMOOTH_W-1:16]);
            op_b = MUL_W'(gain_r);
          end
          3'd1: begin
            op_a          = MUL_W'(smooth_r[15:0]);
            op_b          = MUL_W'(gain_r);
            mac_ctrl.load = 1'b1;
          end
          default: begin
            mac_ctrl.add = 1'b1;
            mac_ctrl.sh  = SH_DN16;
            state_nxt    = ST_PUSH;
          end
        endcase
      end
      ST_PUSH: begin
        hist_push     = 1'b1;
        idx_nxt       = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EMIT;
      end
      // send the whole history, newest first
      ST_EMIT: begin
        if (out_ready) begin
          hist_rotate = 1'b1;
          if (idx_r == IDX_W'(HISTORY_DEPTH - 1)) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bin_cnt_r   <= '0;
      sum_r       <= '0;
      smooth_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bin_cnt_r   <= bin_cnt_nxt;
      sum_r       <= sum_nxt;
      smooth_r    <= smooth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    re_mag_r <= re_mag_nxt;
    im_mag_r <= im_mag_nxt;
    last_r   <= last_nxt;
    level_r  <= level_nxt;
    idx_r    <= idx_nxt;
  end

  // shared multiplier and accumulator
  alrh_mac u_mac (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .ctrl (mac_ctrl),
    .acc  (mac_acc)
  );

  // magnitude square root
  alrh_sqrt #(
    .BIN_WIDTH (BIN_WIDTH)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (mac_acc[2*BIN_WIDTH-1:0]),
    .root     (sq_root),
    .done     (sq_done)
  );

  // brightness history
  alrh_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (hist_push),
    .push_byte (bright),
    .rotate    (hist_rotate),
    .head      (hist_head)
  );

  // ports
  assign idx_ext         = (IDX_W + OFFSET_W)'(idx_r);
  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ring_offset = idx_ext[OFFSET_W-1:0];
  assign out_level_byte  = hist_head;
  assign out_last_entry  = (idx_r == IDX_W'(HISTORY_DEPTH - 1));

`ifndef SYNTHESIS
  // no input request is taken while a run is being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results pending");

  // the final entry of a run returns the block to idle
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_entry) |=> (in_ready && !out_valid))
    else $error("block not idle after final entry");

  // a root only completes while the sequencer waits for it
  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == ST_ROOT))
    else $error("square root finished outside its wait state");

  // the bin counter holds at its limit until the frame ends
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (bin_cnt_r == CNT_MAX) |=> (bin_cnt_r == CNT_MAX || bin_cnt_r == '0))
    else $error("bin counter wrapped");
`endif

endmodule

`default_nettype wire

// ===== rtl/alrh_mac.sv =====
// shared multiplier with registered product and aligned accumulator
// depends on alrh_pkg
`default_nettype none

module alrh_mac (
  input  wire logic                       clk,
  input  wire logic [alrh_pkg::MUL_W-1:0] op_a,
  input  wire logic [alrh_pkg::MUL_W-1:0] op_b,
  input  wire alrh_pkg::mac_ctrl_t        ctrl,
  output logic      [alrh_pkg::ACC_W-1:0] acc
);
  import alrh_pkg::*;

  logic [ACC_W-1:0] prod_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] term;

  // product of the operands issued last cycle, 32 by 32 with a full-width result
  always_ff @(posedge clk) begin
    prod_r <= ACC_W'(op_a) * ACC_W'(op_b);
  end

  // align the product
  always_comb begin
    case (ctrl.sh)
      SH_NONE: term = prod_r;
      SH_UP8:  term = prod_r << 8;
      SH_UP24: term = prod_r << 24;
      SH_DN16: term = prod_r >> 16;
      default: term = prod_r;
    endcase
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc_r <= term;
    end else if (ctrl.add) begin
      acc_r <= acc_r + term;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== rtl/alrh_sqrt.sv =====
// iterative integer square root, one root bit per cycle
// no package dependencies
`default_nettype none

module alrh_sqrt #(
  parameter int BIN_WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [2*BIN_WIDTH-1:0]   radicand,
  output logic      [BIN_WIDTH-1:0]     root,
  output logic                          done
);
  localparam int CNT_W = $clog2(BIN_WIDTH);

  logic [2*BIN_WIDTH-1:0] rad_r, rad_nxt;
  logic [BIN_WIDTH+1:0]   rem_r, rem_nxt;
  logic [BIN_WIDTH-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [BIN_WIDTH+1:0]   rem_sh;
  logic [BIN_WIDTH+1:0]   trial;
  logic                   fits;

  // one digit step: bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh   = {rem_r[BIN_WIDTH-1:0], rad_r[2*BIN_WIDTH-1 -: 2]};
    trial    = {root_r, 2'b01};
    fits     = (rem_sh >= trial);
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(BIN_WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = rad_r << 2;
      rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[BIN_WIDTH-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ===== rtl/alrh_hist.sv =====
// brightness history as a shift line, rotated while its entries are sent out
// depends on alrh_pkg
`default_nettype none

module alrh_hist #(
  parameter int DEPTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [alrh_pkg::BYTE_W-1:0] push_byte,
  input  wire logic                        rotate,
  output logic      [alrh_pkg::BYTE_W-1:0] head
);
  import alrh_pkg::*;

  logic [BYTE_W-1:0] hist_r   [DEPTH];
  logic [BYTE_W-1:0] hist_nxt [DEPTH];

  // push shifts toward the old end, rotate brings the next entry to the head
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    if (push) begin
      hist_nxt[0] = push_byte;
      for (int i = 1; i < DEPTH; i++) begin
        hist_nxt[i] = hist_r[i-1];
      end
    end else if (rotate) begin
      hist_nxt[DEPTH-1] = hist_r[0];
      for (int i = 0; i < DEPTH - 1; i++) begin
        hist_nxt[i] = hist_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

  assign head = hist_r[0];

endmodule

`default_nettype wire
